// ===== hdl/plds_pkg.sv =====
// Shared types and constants for the point-light diffuse shading pipeline.
// No dependencies; every other file in this block imports it.
`default_nettype none

package plds_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 48;

   // iterations done in each register stage of the root and divider pipelines
   localparam int SQRT_STEPS_DEF = 2;
   localparam int DIV_STEPS_DEF  = 2;

   localparam int SQRT_STAGES_DEF = (32 + SQRT_STEPS_DEF - 1) / SQRT_STEPS_DEF;
   localparam int COS_STAGES_DEF  = (32 + DIV_STEPS_DEF - 1) / DIV_STEPS_DEF;
   localparam int FAC_STAGES_DEF  = (64 + DIV_STEPS_DEF - 1) / DIV_STEPS_DEF;
   // geometry 3, falloff 2, color 3, plus the iterative units
   localparam int LATENCY_DEF = 3 + SQRT_STAGES_DEF + COS_STAGES_DEF + 2 +
                                FAC_STAGES_DEF + 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_POS_X      = 3'd0,
      CSR_POS_Y      = 3'd1,
      CSR_POS_Z      = 3'd2,
      CSR_COLOR      = 3'd3,
      CSR_RADIUS     = 3'd4,
      CSR_BRIGHTNESS = 3'd5,
      CSR_LIGHT_TYPE = 3'd6
   } csr_index_type;

   typedef enum logic [2:0] {
      LT_LEGACY  = 3'd0,
      LT_LINEAR  = 3'd1,
      LT_INVERSE = 3'd2,
      LT_INV_SQ  = 3'd3,
      LT_SUN     = 3'd4
   } light_type_type;

   typedef struct packed {
      logic signed [31:0] light_pos_x;
      logic signed [31:0] light_pos_y;
      logic signed [31:0] light_pos_z;
      logic [47:0]        light_color;
      logic [31:0]        falloff_radius;
      logic [31:0]        brightness;
      light_type_type     light_type;
   } cfg_type;

   localparam logic [47:0] COLOR_RST  = 48'h0100_0100_0100;
   localparam logic [31:0] RADIUS_RST = 32'h00C8_0000;
   localparam logic [31:0] BRIGHT_RST = 32'h0001_0000;

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
   } req_type;

   typedef struct packed {
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
      logic        type_error;
   } rsp_type;

   // travels beside the square root
   typedef struct packed {
      logic signed [49:0] dot;
      logic               e;
   } geo_side_type;

   // travels beside the cosine divider
   typedef struct packed {
      logic signed [49:0] dot;
      logic               e;
      logic [31:0]        len1;
   } len_side_type;

endpackage

`default_nettype wire

// ===== hdl/plds_geom.sv =====
// Geometry front end: light vector, range halving, squares and dot product.
// Three register stages. Depends on plds_pkg.
`default_nettype none

module plds_geom (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    in_valid,
   input  plds_pkg::req_type      in_req,
   input  plds_pkg::cfg_type      cfg,
   output logic                   out_valid,
   output logic [63:0]            out_sum,
   output plds_pkg::geo_side_type out_side
);
   import plds_pkg::*;

   logic               vld1_ff, vld2_ff, vld3_ff;
   logic signed [31:0] d_ff [3];
   logic signed [31:0] d_in [3];
   logic signed [15:0] n_ff [3];
   logic               e_ff, e_in;
   logic signed [63:0] sq_ff [3];
   logic signed [47:0] pr_ff [3];
   logic               e2_ff;
   logic [63:0]        sum_ff, sum_in;
   logic signed [49:0] dot_ff, dot_in;
   logic               e3_ff;

   logic signed [32:0] dv [3];
   logic signed [32:0] hv [3];
   logic signed [31:0] lv [3];
   logic signed [31:0] pv [3];
   logic               big;
   logic               sun;

   assign lv[0] = cfg.light_pos_x;
   assign lv[1] = cfg.light_pos_y;
   assign lv[2] = cfg.light_pos_z;
   assign pv[0] = in_req.point_x;
   assign pv[1] = in_req.point_y;
   assign pv[2] = in_req.point_z;
   assign sun   = (cfg.light_type == LT_SUN);

   always_comb begin
      big = 1'b0;
      for (int i = 0; i < 3; i++) begin
         dv[i] = lv[i] - pv[i];
         // truncating halve: bias negatives by one before the shift
         hv[i] = (dv[i] + $signed({32'b0, dv[i][32]})) >>> 1;
         if (dv[i] > 33'sd2147483647 || dv[i] < -33'sd2147483647) begin
            big = 1'b1;
         end
      end
      e_in = big && !sun;
      for (int i = 0; i < 3; i++) begin
         if (sun) begin
            d_in[i] = lv[i];
         end else if (big) begin
            d_in[i] = hv[i][31:0];
         end else begin
            d_in[i] = dv[i][31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
      end else begin
         vld1_ff <= in_valid;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
      end
   end

   always_ff @(posedge clock) begin
      d_ff  <= d_in;
      e_ff  <= e_in;
      n_ff[0] <= in_req.normal_x;
      n_ff[1] <= in_req.normal_y;
      n_ff[2] <= in_req.normal_z;
      for (int i = 0; i < 3; i++) begin
         sq_ff[i] <= d_ff[i] * d_ff[i];
         pr_ff[i] <= d_ff[i] * n_ff[i];
      end
      e2_ff  <= e_ff;
      sum_ff <= sum_in;
      dot_ff <= dot_in;
      e3_ff  <= e2_ff;
   end

   assign sum_in = sq_ff[0] + sq_ff[1] + sq_ff[2];
   assign dot_in = pr_ff[0] + pr_ff[1] + pr_ff[2];

   assign out_valid    = vld3_ff;
   assign out_sum      = sum_ff;
   assign out_side.dot = dot_ff;
   assign out_side.e   = e3_ff;

endmodule

`default_nettype wire

// ===== hdl/plds_sqrt.sv =====
// Pipelined integer square root, digit by digit, STEPS digits per stage.
// Side data rides along unchanged. Depends on plds_pkg.
`default_nettype none

module plds_sqrt #(
   parameter int XW    = 64,
   parameter int STEPS = plds_pkg::SQRT_STEPS_DEF,
   parameter int SW    = 1
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               in_valid,
   input  wire  [XW-1:0]     in_x,
   input  wire  [SW-1:0]     in_side,
   output logic              out_valid,
   output logic [XW/2-1:0]   out_root,
   output logic [SW-1:0]     out_side
);
   import plds_pkg::*;

   localparam int RTW = XW / 2;
   localparam int NST = (RTW + STEPS - 1) / STEPS;
   localparam int RW  = RTW + 3;

   logic            vld_ff  [NST];
   logic [RW-1:0]   rem_ff  [NST];
   logic [RTW-1:0]  root_ff [NST];
   logic [XW-1:0]   xs_ff   [NST];
   logic [SW-1:0]   side_ff [NST];

   genvar g;
   for (g = 0; g < NST; g++) begin : gen_stage
      logic           vld_src;
      logic [RW-1:0]  rem_src, rem_in;
      logic [RTW-1:0] root_src, root_in;
      logic [XW-1:0]  xs_src, xs_in;
      logic [SW-1:0]  side_src;

      if (g == 0) begin : gen_head
         assign vld_src  = in_valid;
         assign rem_src  = '0;
         assign root_src = '0;
         assign xs_src   = in_x;
         assign side_src = in_side;
      end else begin : gen_body
         assign vld_src  = vld_ff[g-1];
         assign rem_src  = rem_ff[g-1];
         assign root_src = root_ff[g-1];
         assign xs_src   = xs_ff[g-1];
         assign side_src = side_ff[g-1];
      end

      always_comb begin : step
         logic [RW-1:0] t;
         logic [RW-1:0] trial;
         rem_in  = rem_src;
         root_in = root_src;
         xs_in   = xs_src;
         for (int j = 0; j < STEPS; j++) begin
            if (g * STEPS + j < RTW) begin
               t     = {rem_in[RW-3:0], xs_in[XW-1:XW-2]};
               trial = RW'({root_in, 2'b01});
               if (t >= trial) begin
                  rem_in  = t - trial;
                  root_in = {root_in[RTW-2:0], 1'b1};
               end else begin
                  rem_in  = t;
                  root_in = {root_in[RTW-2:0], 1'b0};
               end
               xs_in = {xs_in[XW-3:0], 2'b00};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g] <= 1'b0;
         end else begin
            vld_ff[g] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[g]  <= rem_in;
         root_ff[g] <= root_in;
         xs_ff[g]   <= xs_in;
         side_ff[g] <= side_src;
      end
   end

   assign out_valid = vld_ff[NST-1];
   assign out_root  = root_ff[NST-1];
   assign out_side  = side_ff[NST-1];

endmodule

`default_nettype wire

// ===== hdl/plds_div.sv =====
// Pipelined restoring divider, STEPS quotient bits per stage.
// The quotient must fit QW bits. Side data rides along. Depends on plds_pkg.
`default_nettype none

module plds_div #(
   parameter int NW    = 64,
   parameter int DW    = 32,
   parameter int QW    = 32,
   parameter int STEPS = plds_pkg::DIV_STEPS_DEF,
   parameter int SW    = 1
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               in_valid,
   input  wire  [NW-1:0]     in_num,
   input  wire  [DW-1:0]     in_den,
   input  wire  [SW-1:0]     in_side,
   output logic              out_valid,
   output logic [QW-1:0]     out_quo,
   output logic [SW-1:0]     out_side
);
   import plds_pkg::*;

   localparam int NST = (QW + STEPS - 1) / STEPS;

   logic           vld_ff  [NST];
   logic [DW-1:0]  rem_ff  [NST];
   logic [QW-1:0]  low_ff  [NST];
   logic [DW-1:0]  den_ff  [NST];
   logic [SW-1:0]  side_ff [NST];

   genvar g;
   for (g = 0; g < NST; g++) begin : gen_stage
      logic          vld_src;
      logic [DW-1:0] rem_src, rem_in;
      logic [QW-1:0] low_src, low_in;
      logic [DW-1:0] den_src;
      logic [SW-1:0] side_src;

      if (g == 0) begin : gen_head
         assign vld_src  = in_valid;
         assign rem_src  = DW'(in_num[NW-1:QW]);
         assign low_src  = in_num[QW-1:0];
         assign den_src  = in_den;
         assign side_src = in_side;
      end else begin : gen_body
         assign vld_src  = vld_ff[g-1];
         assign rem_src  = rem_ff[g-1];
         assign low_src  = low_ff[g-1];
         assign den_src  = den_ff[g-1];
         assign side_src = side_ff[g-1];
      end

      // low shifts numerator bits out at the top and quotient bits in below
      always_comb begin : step
         logic [DW:0] t;
         logic [DW:0] diff;
         logic        qb;
         rem_in = rem_src;
         low_in = low_src;
         for (int j = 0; j < STEPS; j++) begin
            if (g * STEPS + j < QW) begin
               t    = {rem_in, low_in[QW-1]};
               diff = t - {1'b0, den_src};
               qb   = (t >= {1'b0, den_src});
               rem_in = qb ? diff[DW-1:0] : t[DW-1:0];
               low_in = {low_in[QW-2:0], qb};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g] <= 1'b0;
         end else begin
            vld_ff[g] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[g]  <= rem_in;
         low_ff[g]  <= low_in;
         den_ff[g]  <= den_src;
         side_ff[g] <= side_src;
      end
   end

   assign out_valid = vld_ff[NST-1];
   assign out_quo   = low_ff[NST-1];
   assign out_side  = side_ff[NST-1];

endmodule

`default_nettype wire

// ===== hdl/plds_fall.sv =====
// Falloff setup: builds the numerator and denominator of the light factor
// for each light type. Two register stages. Depends on plds_pkg.
`default_nettype none

module plds_fall (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    in_valid,
   input  wire  [31:0]            in_cos,
   input  plds_pkg::len_side_type in_side,
   input  plds_pkg::cfg_type      cfg,
   output logic                   out_valid,
   output logic [64:0]            out_num,
   output logic [63:0]            out_den,
   output logic                   out_err
);
   import plds_pkg::*;

   logic               vld_m_ff, vld_b_ff;
   logic signed [49:0] dot_ff;
   logic [31:0]        cos_ff, cos_in;
   logic [32:0]        len_ff, len_in;
   logic [63:0]        mlin_ff, mlin_in;
   logic [63:0]        msq_ff, msq_in;
   logic [31:0]        rd;
   logic [64:0]        num_ff, num_in;
   logic [63:0]        den_ff, den_in;
   logic               err_ff, err_in;

   assign cos_in  = (in_side.len1 == '0) ? '0 : in_cos;
   assign len_in  = in_side.e ? {in_side.len1, 1'b0} : {1'b0, in_side.len1};
   assign rd      = cfg.falloff_radius - len_in[31:0];
   assign mlin_in = cos_in * rd;
   assign msq_in  = len_in[31:0] * len_in[31:0];

   always_comb begin
      num_in = '0;
      den_in = 64'd1;
      err_in = 1'b0;
      case (cfg.light_type)
         LT_SUN: begin
            if (!dot_ff[49]) begin
               num_in = {17'b0, dot_ff[49:2]};
            end
         end
         LT_LEGACY, LT_LINEAR: begin
            if (!dot_ff[49] && len_ff < {1'b0, cfg.falloff_radius}) begin
               num_in = {1'b0, mlin_ff};
               den_in = {32'b0, cfg.falloff_radius};
            end
         end
         LT_INVERSE: begin
            if (!dot_ff[49]) begin
               if (len_ff == '0) begin
                  num_in = {1'b0, {64{1'b1}}};
               end else begin
                  num_in = {17'b0, cos_ff, 16'b0};
                  den_in = {31'b0, len_ff};
               end
            end
         end
         LT_INV_SQ: begin
            if (!dot_ff[49]) begin
               if (len_ff == '0) begin
                  num_in = {1'b0, {64{1'b1}}};
               end else if (!len_ff[32]) begin
                  num_in = {1'b0, cos_ff, 32'b0};
                  den_in = msq_ff;
               end
            end
         end
         default: begin
            err_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_m_ff <= 1'b0;
         vld_b_ff <= 1'b0;
      end else begin
         vld_m_ff <= in_valid;
         vld_b_ff <= vld_m_ff;
      end
   end

   always_ff @(posedge clock) begin
      dot_ff  <= in_side.dot;
      cos_ff  <= cos_in;
      len_ff  <= len_in;
      mlin_ff <= mlin_in;
      msq_ff  <= msq_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      err_ff  <= err_in;
   end

   assign out_valid = vld_b_ff;
   assign out_num   = num_ff;
   assign out_den   = den_ff;
   assign out_err   = err_ff;

endmodule

`default_nettype wire

// ===== hdl/plds_color.sv =====
// Color stage: factor times brightness, then times each channel, saturated.
// Three register stages, the last is the result register. Depends on plds_pkg.
`default_nettype none

module plds_color (
   input  wire                clock,
   input  wire                reset,
   input  wire                in_valid,
   input  wire  [63:0]        in_factor,
   input  wire                in_err,
   input  plds_pkg::cfg_type  cfg,
   output logic               out_valid,
   output plds_pkg::rsp_type  out_rsp
);
   import plds_pkg::*;

   logic         vld_p_ff, vld_q_ff, vld_r_ff;
   logic [63:0]  lo_ff, hi_ff;
   logic         err_p_ff, err_q_ff;
   logic [95:0]  prod;
   logic         sat_ff;
   logic [47:0]  g_ff;
   rsp_type      rsp_ff, rsp_in;

   assign prod = {hi_ff, 32'b0} + {32'b0, lo_ff};

   always_comb begin : chan
      logic [15:0] col [3];
      logic [63:0] v   [3];
      logic [15:0] res [3];
      col[0] = cfg.light_color[47:32];
      col[1] = cfg.light_color[31:16];
      col[2] = cfg.light_color[15:0];
      for (int k = 0; k < 3; k++) begin
         v[k] = col[k] * g_ff;
         if (sat_ff) begin
            res[k] = (col[k] != '0) ? 16'hFFFF : 16'h0000;
         end else if (v[k][63:44] != '0) begin
            res[k] = 16'hFFFF;
         end else begin
            res[k] = v[k][43:28];
         end
      end
      rsp_in.red        = res[0];
      rsp_in.green      = res[1];
      rsp_in.blue       = res[2];
      rsp_in.type_error = err_q_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_p_ff <= 1'b0;
         vld_q_ff <= 1'b0;
         vld_r_ff <= 1'b0;
      end else begin
         vld_p_ff <= in_valid;
         vld_q_ff <= vld_p_ff;
         vld_r_ff <= vld_q_ff;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff    <= in_factor[31:0] * cfg.brightness;
      hi_ff    <= in_factor[63:32] * cfg.brightness;
      err_p_ff <= in_err;
      // overflow past 64 bits saturates every nonzero channel
      sat_ff   <= (prod[95:64] != '0);
      g_ff     <= prod[63:16];
      err_q_ff <= err_p_ff;
      rsp_ff   <= rsp_in;
   end

   assign out_valid = vld_r_ff;
   assign out_rsp   = rsp_ff;

endmodule

`default_nettype wire

// ===== hdl/point_light_diffuse_shade.sv =====
// Diffuse shading of one vertex by one light, fully pipelined.
// Input: start/busy command port; a vertex (req_data) transfers at an edge with
// start high and busy low. busy is high during reset and in the cycle after it,
// so from then on a vertex can enter on every clock.
// Output: rsp_valid is high for exactly one cycle with the lit color on
// rsp_data; the receiver has no way to hold it off, results come in order.
// Stages in order: geometry, square root, cosine divider, falloff, factor divider
// and color; the 64-bit factor divider is the longest part. Throughput is one
// vertex per cycle.
// Light setup: csr_we/csr_index/csr_wdata write one register per edge; write
// only while no vertex is in flight. Reset restores the default light and
// empties the pipeline.
// Depends on plds_pkg and the plds_* submodules.
`default_nettype none

module point_light_diffuse_shade #(
   parameter int SQRT_STEPS = plds_pkg::SQRT_STEPS_DEF,
   parameter int DIV_STEPS  = plds_pkg::DIV_STEPS_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              start,
   output logic                             busy,
   input  plds_pkg::req_type                req_data,
   output logic                             rsp_valid,
   output plds_pkg::rsp_type                rsp_data,
   input  wire                              csr_we,
   input  wire  [plds_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire  [plds_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import plds_pkg::*;

   localparam int LATENCY = 3 + (32 + SQRT_STEPS - 1) / SQRT_STEPS +
                            (32 + DIV_STEPS - 1) / DIV_STEPS + 2 +
                            (64 + DIV_STEPS - 1) / DIV_STEPS + 3;

   cfg_type       cfg_ff, cfg_in;
   logic          busy_ff;
   logic          accept;

   logic          geo_valid;
   logic [63:0]   geo_sum;
   geo_side_type  geo_side;

   logic          rt_valid;
   logic [31:0]   rt_len1;
   geo_side_type  rt_side;
   len_side_type  cos_side_in, cos_side;

   logic          cos_valid;
   logic [31:0]   cos_quo;

   logic          fall_valid;
   logic [64:0]   fall_num;
   logic [63:0]   fall_den;
   logic          fall_err;

   logic          fac_valid;
   logic [63:0]   fac_quo;
   logic          fac_err;

   assign accept = start && !busy_ff;
   assign busy   = busy_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_POS_X:      cfg_in.light_pos_x    = csr_wdata[31:0];
            CSR_POS_Y:      cfg_in.light_pos_y    = csr_wdata[31:0];
            CSR_POS_Z:      cfg_in.light_pos_z    = csr_wdata[31:0];
            CSR_COLOR:      cfg_in.light_color    = csr_wdata;
            CSR_RADIUS:     cfg_in.falloff_radius = csr_wdata[31:0];
            CSR_BRIGHTNESS: cfg_in.brightness     = csr_wdata[31:0];
            CSR_LIGHT_TYPE: cfg_in.light_type     = light_type_type'(csr_wdata[2:0]);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff               <= 1'b1;
         cfg_ff.light_pos_x    <= '0;
         cfg_ff.light_pos_y    <= '0;
         cfg_ff.light_pos_z    <= '0;
         cfg_ff.light_color    <= COLOR_RST;
         cfg_ff.falloff_radius <= RADIUS_RST;
         cfg_ff.brightness     <= BRIGHT_RST;
         cfg_ff.light_type     <= LT_LEGACY;
      end else begin
         busy_ff <= 1'b0;
         cfg_ff  <= cfg_in;
      end
   end

   plds_geom u_geom (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_req    (req_data),
      .cfg       (cfg_ff),
      .out_valid (geo_valid),
      .out_sum   (geo_sum),
      .out_side  (geo_side)
   );

   plds_sqrt #(
      .XW    (64),
      .STEPS (SQRT_STEPS),
      .SW    ($bits(geo_side_type))
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (geo_valid),
      .in_x      (geo_sum),
      .in_side   (geo_side),
      .out_valid (rt_valid),
      .out_root  (rt_len1),
      .out_side  (rt_side)
   );

   assign cos_side_in.dot  = rt_side.dot;
   assign cos_side_in.e    = rt_side.e;
   assign cos_side_in.len1 = rt_len1;

   // cosine: (dot << 14) / len1, quotient known to fit 32 bits
   plds_div #(
      .NW    (64),
      .DW    (32),
      .QW    (32),
      .STEPS (DIV_STEPS),
      .SW    ($bits(len_side_type))
   ) u_cos_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rt_valid),
      .in_num    ({rt_side.dot, 14'b0}),
      .in_den    (rt_len1),
      .in_side   (cos_side_in),
      .out_valid (cos_valid),
      .out_quo   (cos_quo),
      .out_side  (cos_side)
   );

   plds_fall u_fall (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cos_valid),
      .in_cos    (cos_quo),
      .in_side   (cos_side),
      .cfg       (cfg_ff),
      .out_valid (fall_valid),
      .out_num   (fall_num),
      .out_den   (fall_den),
      .out_err   (fall_err)
   );

   plds_div #(
      .NW    (65),
      .DW    (64),
      .QW    (64),
      .STEPS (DIV_STEPS),
      .SW    (1)
   ) u_fac_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fall_valid),
      .in_num    (fall_num),
      .in_den    (fall_den),
      .in_side   (fall_err),
      .out_valid (fac_valid),
      .out_quo   (fac_quo),
      .out_side  (fac_err)
   );

   plds_color u_color (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fac_valid),
      .in_factor (fac_quo),
      .in_err    (fac_err),
      .cfg       (cfg_ff),
      .out_valid (rsp_valid),
      .out_rsp   (rsp_data)
   );

endmodule

`default_nettype wire

// ===== hdl/plds_checker.sv =====
// Port-level checks for point_light_diffuse_shade, bound to the top level.
// Depends on plds_pkg; the latency is handed in from the top level's stage counts.
`default_nettype none

module plds_port_checks #(
   parameter int LATENCY = plds_pkg::LATENCY_DEF
) (
   input wire                clock,
   input wire                reset,
   input wire                start,
   input wire                busy,
   input wire                rsp_valid,
   input plds_pkg::rsp_type  rsp_data
);
   import plds_pkg::*;

   a_busy_after_reset: assert property (@(posedge clock) reset |=> busy)
      else $error("busy low right after reset");

   a_quiet_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result strobe right after reset");

   a_result_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result without a vertex transfer at the pipeline latency");

   a_error_is_black: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.type_error |->
         rsp_data.red == '0 && rsp_data.green == '0 && rsp_data.blue == '0)
      else $error("unknown light type with nonzero color");

endmodule

bind point_light_diffuse_shade plds_port_checks #(
   .LATENCY (LATENCY)
) u_plds_port_checks (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// ===== tb/plds_checker.sv =====
// Scoreboard for point_light_diffuse_shade: follows the light setup on the csr port,
// predicts the shaded color of each accepted vertex and compares the results in order.
// Depends on plds_pkg.
`default_nettype none

module plds_checker (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             start,
   input  wire                             busy,
   input  plds_pkg::req_type               req_data,
   input  wire                             rsp_valid,
   input  plds_pkg::rsp_type               rsp_data,
   input  wire                             csr_we,
   input  wire  [plds_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire  [plds_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                              shade_pending,
   output int                              mismatch_count
);
   import plds_pkg::*;

   cfg_type light;
   rsp_type color_q[$];

   function automatic longint unsigned floor_sqrt(longint unsigned x);
      longint unsigned root;
      longint unsigned bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
         if (x >= root + bitv) begin
            x -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   function automatic rsp_type shade_vertex(cfg_type c, req_type v);
      rsp_type res;
      longint lx, ly, lz, dx, dy, dz, dotp;
      longint nx, ny, nz;
      longint unsigned fac, gain, prod, sum2, len1, len, cosq, chan, col, rad, brt;
      bit halved, sat;
      lx = c.light_pos_x; ly = c.light_pos_y; lz = c.light_pos_z;
      nx = v.normal_x;    ny = v.normal_y;    nz = v.normal_z;
      rad = c.falloff_radius;
      brt = c.brightness;
      res = '0;
      sat = 0;
      gain = 0;
      if (c.light_type > LT_SUN) begin
         res.type_error = 1'b1;
         return res;
      end
      if (c.light_type == LT_SUN) begin
         dotp = lx * nx + ly * ny + lz * nz;
         if (dotp < 0) return res;
         fac = 64'(dotp) >> 2;
      end else begin
         dx = lx - longint'(v.point_x);
         dy = ly - longint'(v.point_y);
         dz = lz - longint'(v.point_z);
         halved = 0;
         if (dx > 64'sd2147483647 || dx < -64'sd2147483647 ||
             dy > 64'sd2147483647 || dy < -64'sd2147483647 ||
             dz > 64'sd2147483647 || dz < -64'sd2147483647) begin
            dx = dx / 2; dy = dy / 2; dz = dz / 2;
            halved = 1;
         end
         sum2 = 64'(dx * dx) + 64'(dy * dy) + 64'(dz * dz);
         len1 = floor_sqrt(sum2);
         dotp = dx * nx + dy * ny + dz * nz;
         if (dotp < 0) return res;
         cosq = (len1 != 0) ? ((64'(dotp) << 14) / len1) : 64'd0;
         len = len1 << halved;
         if (c.light_type == LT_LEGACY || c.light_type == LT_LINEAR) begin
            if (len >= rad) fac = 0;
            else fac = cosq * (rad - len) / rad;
         end else if (c.light_type == LT_INVERSE) begin
            fac = (len == 0) ? '1 : ((cosq << 16) / len);
         end else begin
            if (len == 0) fac = '1;
            else if (len >= (64'd1 << 32)) fac = 0;
            else fac = (cosq << 32) / (len * len);
         end
      end
      if (brt != 0 && fac > ({64{1'b1}} / brt)) begin
         sat = 1;
      end else begin
         prod = fac * brt;
         gain = prod >> 16;
      end
      for (int k = 0; k < 3; k++) begin
         col = (c.light_color >> (32 - 16 * k)) & 64'hFFFF;
         if (sat) chan = (col != 0) ? 64'hFFFF : 64'd0;
         else begin
            chan = (col * gain) >> 28;
            if (chan > 64'hFFFF) chan = 64'hFFFF;
         end
         case (k)
            0: res.red = chan[15:0];
            1: res.green = chan[15:0];
            default: res.blue = chan[15:0];
         endcase
      end
      return res;
   endfunction

   task automatic report_miss(string what, rsp_type exp_c, rsp_type got_c);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch %s: expected r=%h g=%h b=%h err=%b, got r=%h g=%h b=%h err=%b",
                  what, exp_c.red, exp_c.green, exp_c.blue, exp_c.type_error,
                  got_c.red, got_c.green, got_c.blue, got_c.type_error);
   endtask

   assign shade_pending = color_q.size();

   initial mismatch_count = 0;

   always @(posedge clock) begin
      rsp_type exp_c;
      if (reset) begin
         light.light_pos_x    <= '0;
         light.light_pos_y    <= '0;
         light.light_pos_z    <= '0;
         light.light_color    <= COLOR_RST;
         light.falloff_radius <= RADIUS_RST;
         light.brightness     <= BRIGHT_RST;
         light.light_type     <= LT_LEGACY;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_POS_X:      light.light_pos_x <= csr_wdata[31:0];
               CSR_POS_Y:      light.light_pos_y <= csr_wdata[31:0];
               CSR_POS_Z:      light.light_pos_z <= csr_wdata[31:0];
               CSR_COLOR:      light.light_color <= csr_wdata[47:0];
               CSR_RADIUS:     light.falloff_radius <= csr_wdata[31:0];
               CSR_BRIGHTNESS: light.brightness <= csr_wdata[31:0];
               CSR_LIGHT_TYPE: light.light_type <= light_type_type'(csr_wdata[2:0]);
               default: ;
            endcase
         end
         if (start && !busy) color_q.push_back(shade_vertex(light, req_data));
         if (rsp_valid) begin
            if (color_q.size() == 0) begin
               report_miss("unexpected transfer", '0, rsp_data);
            end else begin
               exp_c = color_q.pop_front();
               if (rsp_data.red != exp_c.red) report_miss("red", exp_c, rsp_data);
               if (rsp_data.green != exp_c.green) report_miss("green", exp_c, rsp_data);
               if (rsp_data.blue != exp_c.blue) report_miss("blue", exp_c, rsp_data);
               if (rsp_data.type_error != exp_c.type_error)
                  report_miss("type_error", exp_c, rsp_data);
            end
         end
      end
   end

endmodule

`default_nettype wire

// ===== tb/tb_point_light_diffuse_shade.sv =====
// Top of the point_light_diffuse_shade testbench: clock, reset, light setups and vertex
// stimulus; the verdict comes from the failure count of plds_checker.
// Depends on plds_pkg, plds_checker and the block itself.
`default_nettype none

module tb_point_light_diffuse_shade;
   import plds_pkg::*;

   localparam int DRAIN_CYCLES = 90;
   localparam int CYCLE_LIMIT  = 600000;
   localparam logic [2:0] LT_UNKNOWN_LO = 3'd5;
   localparam logic [2:0] LT_UNKNOWN_HI = 3'd7;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   req_type req_data = '0;
   logic rsp_valid;
   rsp_type rsp_data;
   logic csr_we = 0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   int shade_pending, mismatch_count;
   int cycle_count = 0;
   cfg_type light;

   point_light_diffuse_shade u_top (
      .clock, .reset, .start, .busy, .req_data, .rsp_valid, .rsp_data,
      .csr_we, .csr_index, .csr_wdata
   );

   plds_checker u_checker (
      .clock, .reset, .start, .busy, .req_data, .rsp_valid, .rsp_data,
      .csr_we, .csr_index, .csr_wdata, .shade_pending, .mismatch_count
   );

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** point_light_diffuse_shade: FAILED **");
         $finish;
      end
   end

   // stop sending, then wait until every result is back
   task automatic wait_idle();
      start <= 1'b0;
      while (shade_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic load_light(cfg_type c);
      light = c;
      for (int i = 0; i <= CSR_LIGHT_TYPE; i++) begin
         csr_we    <= 1'b1;
         csr_index <= i[CSR_IDX_W-1:0];
         case (csr_index_type'(i))
            CSR_POS_X:      csr_wdata <= 48'(unsigned'(c.light_pos_x));
            CSR_POS_Y:      csr_wdata <= 48'(unsigned'(c.light_pos_y));
            CSR_POS_Z:      csr_wdata <= 48'(unsigned'(c.light_pos_z));
            CSR_COLOR:      csr_wdata <= c.light_color;
            CSR_RADIUS:     csr_wdata <= 48'(c.falloff_radius);
            CSR_BRIGHTNESS: csr_wdata <= 48'(c.brightness);
            default:        csr_wdata <= {$urandom, 16'(c.light_type)};
         endcase
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   // one vertex transfer, then a random gap if allowed
   task automatic send_vertex(req_type v, bit allow_gap);
      int gap;
      gap = allow_gap ? $urandom_range(0, 8) : 0;
      req_data <= v;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic req_type near_vertex(int spread);
      req_type v;
      v.point_x  = light.light_pos_x + $signed($urandom_range(0, 2 * spread)) - spread;
      v.point_y  = light.light_pos_y + $signed($urandom_range(0, 2 * spread)) - spread;
      v.point_z  = light.light_pos_z + $signed($urandom_range(0, 2 * spread)) - spread;
      v.normal_x = 16'($urandom_range(0, 32767) - 16384);
      v.normal_y = 16'($urandom_range(0, 32767) - 16384);
      v.normal_z = 16'($urandom_range(0, 32767) - 16384);
      return v;
   endfunction

   function automatic req_type random_vertex();
      req_type v;
      case ($urandom_range(0, 9))
         0, 1: v = {$urandom, $urandom, $urandom, 16'($urandom), 16'($urandom), 16'($urandom)};
         2, 3: v = near_vertex(1 << 12);
         default: v = near_vertex(1 << 22);
      endcase
      return v;
   endfunction

   function automatic cfg_type random_light();
      cfg_type c;
      int pick;
      pick = $urandom_range(0, 4);
      c.light_pos_x    = (pick == 0) ? $urandom : $signed($urandom_range(0, 1 << 26)) - (1 << 25);
      c.light_pos_y    = (pick == 0) ? $urandom : $signed($urandom_range(0, 1 << 26)) - (1 << 25);
      c.light_pos_z    = (pick == 0) ? $urandom : $signed($urandom_range(0, 1 << 26)) - (1 << 25);
      c.light_color    = {16'($urandom), $urandom};
      c.falloff_radius = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 1 << 24);
      c.brightness     = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1 << 18);
      pick = $urandom_range(0, 11);
      c.light_type     = light_type_type'((pick > 7) ? $urandom_range(0, 4) : pick);
      return c;
   endfunction

   initial begin
      cfg_type c;
      req_type v;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (busy) @(posedge clock);

      // directed: default light off origin, sun, every falloff, unknown types, extremes
      c = '{32'sh0010_0000, 32'sh0020_0000, -32'sh0008_0000, COLOR_RST, RADIUS_RST,
            BRIGHT_RST, LT_LEGACY};
      load_light(c);
      for (int t = 0; t <= 7; t++) begin
         c.light_type = light_type_type'(t);
         if (t > 0) begin
            wait_idle();
            load_light(c);
         end
         // zero distance, facing toward, facing away
         send_vertex('{c.light_pos_x, c.light_pos_y, c.light_pos_z, 16'sd16384, 0, 0}, 0);
         send_vertex('{0, 0, 0, 16'sd9000, 16'sd9000, -16'sd5000}, 1);
         send_vertex('{0, 0, 0, -16'sd9000, -16'sd9000, 16'sd5000}, 0);
      end
      wait_idle();
      // halved distance, full brightness overflow, radius zero, zero color channel
      c = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 48'hFFFF_0000_8000,
            32'h0, 32'hFFFF_FFFF, LT_INVERSE};
      load_light(c);
      send_vertex('{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                    16'sh7FFF, -16'sh8000, 16'sh7FFF}, 0);
      send_vertex('{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                    -16'sh8000, 16'sh7FFF, -16'sh8000}, 1);
      send_vertex('{c.light_pos_x, c.light_pos_y, c.light_pos_z, 16'sh7FFF, 0, 0}, 0);
      wait_idle();
      c.light_type = LT_LINEAR;
      c.brightness = '0;
      load_light(c);
      send_vertex('{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, -1, 1, -1}, 0);
      wait_idle();
      c = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 48'hFFFF_FFFF_FFFF,
            32'hFFFF_FFFF, 32'hFFFF_FFFF, LT_SUN};
      load_light(c);
      send_vertex('{0, 0, 0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF}, 0);
      send_vertex('{0, 0, 0, -16'sh8000, -16'sh8000, -16'sh8000}, 0);
      wait_idle();

      // random phases, each with a fresh light; each phase ends by waiting out all results
      for (int ph = 0; ph < 20; ph++) begin
         load_light(random_light());
         for (int i = 0; i < 50; i++) send_vertex(random_vertex(), $urandom_range(0, 3) != 0);
         start <= 1'b0;
         wait_idle();
      end
      // unknown light types at both edges of their range, which random phases may miss
      for (int t = LT_UNKNOWN_LO; t <= LT_UNKNOWN_HI; t += 2) begin
         c = random_light();
         c.light_type = light_type_type'(t);
         load_light(c);
         for (int i = 0; i < 5; i++) send_vertex(random_vertex(), 1);
         start <= 1'b0;
         wait_idle();
      end

      if (mismatch_count == 0) begin
         $display("** point_light_diffuse_shade: PASSED **");
      end else begin
         $display("** point_light_diffuse_shade: FAILED **");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
hdl/plds_pkg.sv
hdl/plds_geom.sv
hdl/plds_sqrt.sv
hdl/plds_div.sv
hdl/plds_fall.sv
hdl/plds_color.sv
hdl/point_light_diffuse_shade.sv
hdl/plds_checker.sv
tb/plds_checker.sv
tb/tb_point_light_diffuse_shade.sv
